@@ rtl/stereo_level_meter_defines.svh @@
// Assertion macros for the stereo level meter.
`ifndef STEREO_LEVEL_METER_DEFINES_SVH
`define STEREO_LEVEL_METER_DEFINES_SVH
`ifndef SYNTHESIS
`define SLM_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("slm check failed");
`define SLM_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("slm check failed");
`else
`define SLM_ASSERT_IMP(label, clk, rst, cond, prop)
`define SLM_ASSERT_NXT(label, clk, rst, cond, prop)
`endif
`endif

@@ rtl/slm_pkg.sv @@
`default_nettype none
package slm_pkg;
   localparam int SampleBitsDefault = 16;
   localparam int CountBitsDefault  = 24;
   localparam int CaptureReset      = 24000 * 2;

   typedef struct packed {
      logic accum;    // accumulate one frame
      logic start;    // start divide of totals
   } slm_cmd_type;

   typedef struct packed {
      logic report;   // frame just added closes capture
      logic done;     // report math finished
   } slm_sts_type;
endpackage
`default_nettype wire

@@ rtl/stereo_level_meter.sv @@
`default_nettype none
// channel | dir | handshake           | content
// req     | in  | tvalid/tready       | one stereo frame
// rsp     | out | tvalid/tready       | one level report
// csr     | in  | wen                 | capture_frames
// A frame is taken in ST_IDLE, then its capture-end check runs in ST_CHK.
// A frame that closes a capture blocks req until its report is transferred:
// the check, 55 divide steps (2*SAMPLE+COUNT-1), 1 load, 28 root steps,
// the done handoff and the rsp transfer; no frame is taken meanwhile.
// Reset: synchronous, clears all totals; capture_frames returns to 48000.
// A stalled rsp holds the report and blocks req until transferred.
module stereo_level_meter
   import slm_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int COUNT_BITS  = CountBitsDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [COUNT_BITS-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // left_sample, right_sample
   input  wire logic [2*SAMPLE_BITS-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // left_mean_abs, left_rms, left_peak, right_mean_abs, right_rms,
   // right_peak, frames_counted, zero pad
   output logic [((6*SAMPLE_BITS-2+COUNT_BITS+7)/8)*8-1:0] rsp_tdata,
   // pick_right
   output logic                       rsp_tuser
);
   localparam int UW = 6*SAMPLE_BITS-2+COUNT_BITS;
   localparam int PW = ((UW+7)/8)*8;

   logic [COUNT_BITS-1:0] cap_ff;
   slm_cmd_type cmd;
   slm_sts_type sts;
   logic [SAMPLE_BITS-1:0] lma, lrm, rma, rrm;
   logic [SAMPLE_BITS-2:0] lpk, rpk;
   logic [COUNT_BITS-1:0]  fc;

   always_ff @(posedge clock) begin
      if (reset)        cap_ff <= COUNT_BITS'(CaptureReset);
      else if (csr_wen) cap_ff <= csr_wdata;
   end

   slm_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts
   );

   slm_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock, .reset, .capture_frames(cap_ff),
      .left_sample(req_tdata[SAMPLE_BITS-1:0]),
      .right_sample(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .cmd, .sts,
      .left_mean_abs(lma), .left_rms(lrm), .left_peak(lpk),
      .right_mean_abs(rma), .right_rms(rrm), .right_peak(rpk),
      .frames_counted(fc), .pick_right(rsp_tuser)
   );

   assign rsp_tdata = PW'({fc, rpk, rrm, rma, lpk, lrm, lma});
endmodule
`default_nettype wire

@@ rtl/slm_ctrl.sv @@
`default_nettype none
module slm_ctrl
   import slm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output slm_cmd_type      cmd,
   input  wire slm_sts_type sts
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CHK  = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accum = 1'b1;
               state_in  = ST_CHK;
            end
         end
         ST_CHK: begin
            if (sts.report) begin
               cmd.start = 1'b1;
               state_in  = ST_CALC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CALC: if (sts.done) state_in = ST_OUT;
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ rtl/slm_datapath.sv @@
`default_nettype none
module slm_datapath
   import slm_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int COUNT_BITS  = CountBitsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [COUNT_BITS-1:0]  capture_frames,
   input  wire logic [SAMPLE_BITS-1:0] left_sample,
   input  wire logic [SAMPLE_BITS-1:0] right_sample,
   input  wire slm_cmd_type            cmd,
   output slm_sts_type                 sts,
   output logic [SAMPLE_BITS-1:0]      left_mean_abs,
   output logic [SAMPLE_BITS-1:0]      left_rms,
   output logic [SAMPLE_BITS-2:0]      left_peak,
   output logic [SAMPLE_BITS-1:0]      right_mean_abs,
   output logic [SAMPLE_BITS-1:0]      right_rms,
   output logic [SAMPLE_BITS-2:0]      right_peak,
   output logic [COUNT_BITS-1:0]       frames_counted,
   output logic                        pick_right
);
   localparam int AW = SAMPLE_BITS + COUNT_BITS;         // abs total width
   localparam int QW = 2 * SAMPLE_BITS + COUNT_BITS - 1; // square total width
   localparam int DW = QW + COUNT_BITS;                  // divide shift width
   localparam int RW = QW / 2 + 1;                        // root width
   localparam int CW = $clog2(QW + 1);

   logic [AW-1:0] labs_ff, rabs_ff;
   logic [QW-1:0] lsq_ff, rsq_ff;
   logic [SAMPLE_BITS-2:0] lpk_ff, rpk_ff;
   logic [COUNT_BITS-1:0]  tally_ff;
   logic [SAMPLE_BITS-1:0] lmag, rmag;
   logic [SAMPLE_BITS-2:0] lclp, rclp;
   logic [COUNT_BITS-1:0]  tally_inc;

   function automatic logic [SAMPLE_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
      mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   assign lmag = mag(left_sample);
   assign rmag = mag(right_sample);
   assign lclp = lmag[SAMPLE_BITS-1] ? '1 : lmag[SAMPLE_BITS-2:0];
   assign rclp = rmag[SAMPLE_BITS-1] ? '1 : rmag[SAMPLE_BITS-2:0];
   assign tally_inc = tally_ff + 1'b1;

   // square registered before the add
   logic [2*SAMPLE_BITS-1:0] lsqr_ff, rsqr_ff;
   logic                     sq_pend_ff;

   // restoring dividers on the four totals, one quotient bit a cycle
   logic [DW-1:0] ldn_ff, rdn_ff;     // remainder:dividend shift regs, square
   logic [AW+COUNT_BITS-1:0] lan_ff, ran_ff;
   logic [CW-1:0] cnt_ff;
   logic [1:0]    phase_ff;           // 0 idle, 1 divide, 2 root
   logic [COUNT_BITS-1:0] div_ff;
   logic [QW-1:0] lq_ff, rq_ff;
   logic [SAMPLE_BITS-1:0] laq_ff, raq_ff;

   // report fields held for rsp
   logic                   done_ff;
   logic [COUNT_BITS-1:0]  frames_ff;
   logic [SAMPLE_BITS-2:0] lpko_ff, rpko_ff;
   logic                   pick_ff;

   // square root state
   logic [QW-1:0] lrem_ff, rrem_ff;
   logic [RW-1:0] lroot_ff, rroot_ff;

   // partial remainder needs one bit above the divisor after the shift
   function automatic logic [DW-1:0] dstep(input logic [DW-1:0] x,
                                           input logic [COUNT_BITS-1:0] d);
      logic [DW-1:0] s;
      logic [COUNT_BITS:0] hi;
      s  = x << 1;
      hi = {x[DW-1], s[DW-1:QW]};
      if (hi >= {1'b0, d}) begin
         s[DW-1:QW] = COUNT_BITS'(hi - {1'b0, d});
         s[0] = 1'b1;
      end
      dstep = s;
   endfunction

   function automatic logic [AW+COUNT_BITS-1:0] astep(input logic [AW+COUNT_BITS-1:0] x,
                                                     input logic [COUNT_BITS-1:0] d);
      logic [AW+COUNT_BITS-1:0] s;
      logic [COUNT_BITS:0] hi;
      s  = x << 1;
      hi = {x[AW+COUNT_BITS-1], s[AW+COUNT_BITS-1:AW]};
      if (hi >= {1'b0, d}) begin
         s[AW+COUNT_BITS-1:AW] = COUNT_BITS'(hi - {1'b0, d});
         s[0] = 1'b1;
      end
      astep = s;
   endfunction

   // one root bit per cycle: test (root<<2|1)... classic digit recurrence
   logic [QW+1:0] ltr, rtr, lrm2, rrm2;
   logic [CW-1:0] pair;
   // root steps run with cnt 1..RW, top pair first
   assign pair = CW'(RW) - cnt_ff;
   assign lrm2 = {lrem_ff, 2'b00};
   assign rrm2 = {rrem_ff, 2'b00};
   assign ltr = {QW'(lroot_ff), 2'b01};
   assign rtr = {QW'(rroot_ff), 2'b01};
   logic [1:0] lpair, rpair;
   logic [2*RW-1:0] lqx, rqx;
   assign lqx = (2*RW)'(lq_ff);
   assign rqx = (2*RW)'(rq_ff);
   assign lpair = lqx[2*pair +: 2];
   assign rpair = rqx[2*pair +: 2];
   logic [QW+1:0] lcand, rcand;
   assign lcand = lrm2 | (QW+2)'(lpair);
   assign rcand = rrm2 | (QW+2)'(rpair);

   always_ff @(posedge clock) begin
      if (reset) begin
         labs_ff <= '0; rabs_ff <= '0; lsq_ff <= '0; rsq_ff <= '0;
         lpk_ff <= '0; rpk_ff <= '0; tally_ff <= '0;
         sq_pend_ff <= 1'b0; phase_ff <= 2'd0; cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff    <= (phase_ff == 2'd2) && (cnt_ff == CW'(RW));
         sq_pend_ff <= cmd.accum;
         if (cmd.accum) begin
            lsqr_ff  <= lmag * lmag;
            rsqr_ff  <= rmag * rmag;
            labs_ff  <= labs_ff + AW'(lmag);
            rabs_ff  <= rabs_ff + AW'(rmag);
            if (lclp > lpk_ff) lpk_ff <= lclp;
            if (rclp > rpk_ff) rpk_ff <= rclp;
            tally_ff <= tally_inc;
         end
         if (sq_pend_ff && !cmd.start) begin
            lsq_ff <= lsq_ff + QW'(lsqr_ff);
            rsq_ff <= rsq_ff + QW'(rsqr_ff);
         end
         if (cmd.start) begin
            ldn_ff <= DW'(lsq_ff + QW'(lsqr_ff));
            rdn_ff <= DW'(rsq_ff + QW'(rsqr_ff));
            lan_ff <= (AW+COUNT_BITS)'(labs_ff);
            ran_ff <= (AW+COUNT_BITS)'(rabs_ff);
            div_ff <= tally_ff;
            frames_ff <= tally_ff;
            lpko_ff   <= lpk_ff;
            rpko_ff   <= rpk_ff;
            pick_ff   <= ({1'b0, rabs_ff} > {labs_ff, 1'b0}) && (rpk_ff > lpk_ff);
            labs_ff <= '0; rabs_ff <= '0; lpk_ff <= '0; rpk_ff <= '0;
            lsq_ff <= '0; rsq_ff <= '0; tally_ff <= '0;
            cnt_ff <= '0; phase_ff <= 2'd1;
         end else if (phase_ff == 2'd1) begin
            ldn_ff <= dstep(ldn_ff, div_ff);
            rdn_ff <= dstep(rdn_ff, div_ff);
            if (cnt_ff < CW'(AW)) begin
               lan_ff <= astep(lan_ff, div_ff);
               ran_ff <= astep(ran_ff, div_ff);
            end
            if (cnt_ff == CW'(QW - 1)) begin
               phase_ff <= 2'd2; cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            lq_ff <= '0; rq_ff <= '0;
         end else if (phase_ff == 2'd2) begin
            if (cnt_ff == '0) begin
               lq_ff <= ldn_ff[QW-1:0]; rq_ff <= rdn_ff[QW-1:0];
               laq_ff <= lan_ff[SAMPLE_BITS-1:0]; raq_ff <= ran_ff[SAMPLE_BITS-1:0];
               lrem_ff <= '0; rrem_ff <= '0; lroot_ff <= '0; rroot_ff <= '0;
               cnt_ff <= CW'(1);
            end else begin
               if (lcand >= ltr) begin
                  lrem_ff <= QW'(lcand - ltr); lroot_ff <= {lroot_ff[RW-2:0], 1'b1};
               end else begin
                  lrem_ff <= QW'(lcand); lroot_ff <= {lroot_ff[RW-2:0], 1'b0};
               end
               if (rcand >= rtr) begin
                  rrem_ff <= QW'(rcand - rtr); rroot_ff <= {rroot_ff[RW-2:0], 1'b1};
               end else begin
                  rrem_ff <= QW'(rcand); rroot_ff <= {rroot_ff[RW-2:0], 1'b0};
               end
               if (cnt_ff == CW'(RW)) begin
                  phase_ff <= 2'd0;
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      sts.report = (tally_ff >= capture_frames);
      sts.done   = done_ff;
   end

   assign left_mean_abs  = laq_ff;
   assign right_mean_abs = raq_ff;
   assign left_rms       = lroot_ff[SAMPLE_BITS-1:0];
   assign right_rms      = rroot_ff[SAMPLE_BITS-1:0];
   assign left_peak      = lpko_ff;
   assign right_peak     = rpko_ff;
   assign frames_counted = frames_ff;
   assign pick_right     = pick_ff;

   `include "stereo_level_meter_defines.svh"
   `SLM_ASSERT_NXT(a_start_div, clock, reset, cmd.start, phase_ff == 2'd1 && tally_ff == '0)
   `SLM_ASSERT_IMP(a_no_overlap, clock, reset, cmd.accum, phase_ff == 2'd0)
   `SLM_ASSERT_NXT(a_done_idle, clock, reset, done_ff, phase_ff == 2'd0)
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
// Level meter bench: directed table then random frames, checked against an
// in-bench accumulator model. Reports are compared field by field in order.
module tb_top
   import slm_pkg::*;
();

   localparam int SB = 16;
   localparam int CB = 24;
   localparam int RW = ((6*SB-2+CB+7)/8)*8;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [15:0] l_mean;
      logic [15:0] l_rms;
      logic [14:0] l_peak;
      logic [15:0] r_mean;
      logic [15:0] r_rms;
      logic [14:0] r_peak;
      logic [23:0] frames;
      logic        pick_r;
   } level_report_type;

   typedef struct {
      logic [15:0] l;
      logic [15:0] r;
      logic        has_exp;    // typed-in report follows
      logic [14:0] l_peak;
      logic [14:0] r_peak;
      logic        pick_r;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen = 1'b0;
   logic [CB-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [2*SB-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RW-1:0] rsp_tdata;
   logic rsp_tuser;

   stereo_level_meter i_dut (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // meter model state
   logic [23:0] capture_len;
   logic [39:0] l_abs_sum, r_abs_sum;
   logic [54:0] l_sq_sum, r_sq_sum;
   logic [14:0] l_peak_max, r_peak_max;
   logic [23:0] tally;

   level_report_type pending_reports[$];
   int mismatches = 0;
   int reports_seen = 0;
   int frames_sent = 0;
   int send_idle_pct = 12;
   int recv_idle_pct = 45;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   task automatic clear_totals();
      l_abs_sum = 0; r_abs_sum = 0; l_sq_sum = 0; r_sq_sum = 0;
      l_peak_max = 0; r_peak_max = 0; tally = 0;
   endtask

   // accumulate one frame, queue the report when the capture closes
   task automatic meter_frame(input logic [15:0] ls, input logic [15:0] rs);
      logic [16:0] lm, rm;
      logic [14:0] lc, rc;
      level_report_type rep;
      logic [63:0] n;
      lm = ls[15] ? 17'h10000 - {1'b0, ls} : {1'b0, ls};
      rm = rs[15] ? 17'h10000 - {1'b0, rs} : {1'b0, rs};
      lc = (lm > 17'd32767) ? 15'h7fff : lm[14:0];
      rc = (rm > 17'd32767) ? 15'h7fff : rm[14:0];
      l_abs_sum += 40'(lm);
      r_abs_sum += 40'(rm);
      l_sq_sum += 55'(lm) * 55'(lm);
      r_sq_sum += 55'(rm) * 55'(rm);
      if (lc > l_peak_max) l_peak_max = lc;
      if (rc > r_peak_max) r_peak_max = rc;
      tally = tally + 24'd1;
      if (tally < capture_len) return;
      n = 64'(tally);
      rep.l_mean = 16'(64'(l_abs_sum) / n);
      rep.l_rms  = 16'(int_sqrt(64'(l_sq_sum) / n));
      rep.l_peak = l_peak_max;
      rep.r_mean = 16'(64'(r_abs_sum) / n);
      rep.r_rms  = 16'(int_sqrt(64'(r_sq_sum) / n));
      rep.r_peak = r_peak_max;
      rep.frames = tally;
      rep.pick_r = (64'(r_abs_sum) > 64'(l_abs_sum) * 2) && (r_peak_max > l_peak_max);
      pending_reports.push_back(rep);
      clear_totals();
   endtask

   // send one frame, honoring sender idling; tvalid stays up after the
   // transfer so back-to-back frames need no gap, stop_sender drops it
   task automatic send_frame(input logic [15:0] ls, input logic [15:0] rs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rs, ls};
      meter_frame(ls, rs);
      do @(posedge clock); while (!req_tready);
      frames_sent++;
   endtask

   task automatic stop_sender();
      req_tvalid <= 1'b0;
   endtask

   task automatic write_capture(input logic [23:0] len);
      stop_sender();
      wait (pending_reports.size() == 0);
      repeat (150) @(posedge clock);   // report math may still be draining
      csr_wen <= 1'b1;
      csr_wdata <= len;
      capture_len = len;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // receiver: random stall, compare each transfer to oldest expectation
   always @(posedge clock) begin
      level_report_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.l_mean = rsp_tdata[15:0];
            got.l_rms  = rsp_tdata[31:16];
            got.l_peak = rsp_tdata[46:32];
            got.r_mean = rsp_tdata[62:47];
            got.r_rms  = rsp_tdata[78:63];
            got.r_peak = rsp_tdata[93:79];
            got.frames = rsp_tdata[117:94];
            got.pick_r = rsp_tuser;
            reports_seen++;
            if (pending_reports.size() == 0) begin
               report_mismatch("unexpected report", 64'd1, 64'd0);
            end else begin
               want = pending_reports.pop_front();
               check_field("l_mean", 64'(got.l_mean), 64'(want.l_mean));
               check_field("l_rms", 64'(got.l_rms), 64'(want.l_rms));
               check_field("l_peak", 64'(got.l_peak), 64'(want.l_peak));
               check_field("r_mean", 64'(got.r_mean), 64'(want.r_mean));
               check_field("r_rms", 64'(got.r_rms), 64'(want.r_rms));
               check_field("r_peak", 64'(got.r_peak), 64'(want.r_peak));
               check_field("frames", 64'(got.frames), 64'(want.frames));
               check_field("pick_r", 64'(got.pick_r), 64'(want.pick_r));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("watchdog expired, %0d reports outstanding", pending_reports.size());
         $display("FAIL stereo_level_meter");
         $finish;
      end
   end

   // directed frames: extremes, most negative sample, pick flag both ways
   frame_row_type dir_rows[10] = '{
      '{16'h0000, 16'h0000, 1'b1, 15'd0,     15'd0,     1'b0},
      '{16'h7fff, 16'h0000, 1'b1, 15'h7fff,  15'd0,     1'b0},
      '{16'h8000, 16'h8000, 1'b1, 15'h7fff,  15'h7fff,  1'b0},
      '{16'h0001, 16'h8000, 1'b1, 15'd1,     15'h7fff,  1'b1},
      '{16'hffff, 16'h0003, 1'b1, 15'd1,     15'd3,     1'b1},
      '{16'h0002, 16'h0004, 1'b1, 15'd2,     15'd4,     1'b0},
      '{16'h1234, 16'hedcc, 1'b0, 15'd0,     15'd0,     1'b0},
      '{16'h5555, 16'haaaa, 1'b0, 15'd0,     15'd0,     1'b0},
      '{16'h8001, 16'h7ffe, 1'b0, 15'd0,     15'd0,     1'b0},
      '{16'h00ff, 16'hff00, 1'b0, 15'd0,     15'd0,     1'b0}
   };

   task automatic random_frames(input int count);
      logic [15:0] ls, rs;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(5))
            0: begin ls = 16'h8000; rs = 16'(($urandom_range(1)) ? 16'h7fff : 16'h0); end
            1: begin ls = 16'($urandom_range(15)); rs = 16'($urandom); end
            default: begin ls = 16'($urandom); rs = 16'($urandom); end
         endcase
         send_frame(ls, rs);
      end
   endtask

   initial begin
      level_report_type typed;
      capture_len = 24'(CaptureReset);
      clear_totals();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single-frame captures: report fields readable directly
      write_capture(24'd1);
      foreach (dir_rows[k]) begin
         send_frame(dir_rows[k].l, dir_rows[k].r);
         if (dir_rows[k].has_exp) begin
            typed = pending_reports[$];
            check_field("row l_peak", 64'(typed.l_peak), 64'(dir_rows[k].l_peak));
            check_field("row r_peak", 64'(typed.r_peak), 64'(dir_rows[k].r_peak));
            check_field("row pick", 64'(typed.pick_r), 64'(dir_rows[k].pick_r));
         end
      end
      // zero length behaves like one
      write_capture(24'd0);
      send_frame(16'h8000, 16'h7fff);
      send_frame(16'h0, 16'hffff);
      // lower the length below a partial tally
      write_capture(24'd6);
      send_frame(16'h0100, 16'h0200);
      send_frame(16'h0100, 16'h0200);
      send_frame(16'h0100, 16'h0200);
      write_capture(24'd2);
      send_frame(16'h0100, 16'h0200);
      // maximum length: partial accumulation only, reported once the length is lowered
      write_capture(24'hffffff);
      send_frame(16'h7fff, 16'h8000);
      write_capture(24'd1);   // closes the max-length partial on next frame
      send_frame(16'h0, 16'h0);

      send_idle_pct = 12; recv_idle_pct = 45;
      write_capture(24'd3);
      random_frames(100);
      write_capture(24'd1);
      random_frames(50);
      send_idle_pct = 45; recv_idle_pct = 12;
      write_capture(24'd7);
      random_frames(150);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_capture(24'd2);
      random_frames(150);
      write_capture(24'd17);
      random_frames(150);
      stop_sender();

      wait (pending_reports.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d frames, %0d reports, lengths 0..2^24-1 and the -32768 edge",
               frames_sent, reports_seen);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("PASS stereo_level_meter");
      else
         $display("FAIL stereo_level_meter");
      $finish;
   end
endmodule
`default_nettype wire
